FILE: src/rpc_pkg.sv
// Shared types, constants and helpers for the rectangle polygon clipper.
package rpc_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int COORD_WIDTH     = 32;
    localparam int BORDER_WIDTH    = 16;
    localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
    localparam int MUL_LO_WIDTH    = (DIFF_WIDTH + 1) / 2;
    localparam int MUL_HI_WIDTH    = DIFF_WIDTH - MUL_LO_WIDTH;
    localparam int PROD_WIDTH      = 2 * DIFF_WIDTH;
    localparam int CNT_WIDTH       = $clog2(DIFF_WIDTH);

    // Register indexes of the configuration port
    localparam logic [1:0] REG_X_MIN = 2'd0;
    localparam logic [1:0] REG_X_MAX = 2'd1;
    localparam logic [1:0] REG_Y_MIN = 2'd2;
    localparam logic [1:0] REG_Y_MAX = 2'd3;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
    } vtx_t;

    // One request between cells: a vertex, an end-of-polygon mark, or both
    typedef struct packed {
        vtx_t v;
        logic has_vertex;
        logic is_end;
    } tok_t;

    // Border that one cell clips against
    typedef struct packed {
        logic signed [BORDER_WIDTH-1:0] border;
        logic                           on_x;
        logic                           is_max;
    } edge_cfg_t;

    // Magnitude of a signed difference
    function automatic logic [DIFF_WIDTH-1:0] mag(input logic signed [DIFF_WIDTH-1:0] v);
        logic [DIFF_WIDTH-1:0] r;
        r = v[DIFF_WIDTH-1] ? DIFF_WIDTH'(-v) : DIFF_WIDTH'(v);
        return r;
    endfunction

endpackage

FILE: src/rpc_cell.sv
// One clipping cell: clips the vertex stream against a single border.
module rpc_cell
    import rpc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  edge_cfg_t cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  tok_t      in_tok,
    output logic      out_valid,
    input  logic      out_ready,
    output tok_t      out_tok
);

    typedef enum logic [10:0] {
        ST_IDLE      = 11'b000_0000_0001,
        ST_VERT      = 11'b000_0000_0010,
        ST_EDGE      = 11'b000_0000_0100,
        ST_MUL1      = 11'b000_0000_1000,
        ST_MUL2      = 11'b000_0001_0000,
        ST_DIV       = 11'b000_0010_0000,
        ST_RND       = 11'b000_0100_0000,
        ST_EMIT_C    = 11'b000_1000_0000,
        ST_EMIT_B    = 11'b001_0000_0000,
        ST_CHECK_END = 11'b010_0000_0000,
        ST_EMIT_END  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    tok_t   tok_reg, tok_next;
    vtx_t   first_reg, first_next;
    vtx_t   prev_reg, prev_next;
    vtx_t   a_reg, a_next;
    vtx_t   b_reg, b_next;
    vtx_t   c_reg, c_next;
    logic   started_reg, started_next;
    logic   closing_reg, closing_next;
    logic   ib_reg, ib_next;
    logic   neg_reg, neg_next;
    logic   out_valid_reg, out_valid_next;
    tok_t   out_tok_reg, out_tok_next;
    logic [DIFF_WIDTH-1:0]               dmag_reg, dmag_next;
    logic [DIFF_WIDTH-1:0]               nmag_reg, nmag_next;
    logic [DIFF_WIDTH-1:0]               mmag_reg, mmag_next;
    logic [DIFF_WIDTH+MUL_LO_WIDTH-1:0]  plo_reg, plo_next;
    logic [DIFF_WIDTH-1:0]               rem_reg, rem_next;
    logic [DIFF_WIDTH-1:0]               low_reg, low_next;
    logic [DIFF_WIDTH-1:0]               q_reg, q_next;
    logic [CNT_WIDTH-1:0]                cnt_reg, cnt_next;

    logic signed [COORD_WIDTH-1:0] bd, au, bu, av, bv;
    logic signed [DIFF_WIDTH-1:0]  dv, dn, dm;
    logic                          ia, ib;
    logic [PROD_WIDTH-1:0]         prod;
    logic [DIFF_WIDTH:0]           trial;
    logic                          ge, rnd, can_load;
    logic [DIFF_WIDTH:0]           q_rnd;
    logic signed [DIFF_WIDTH+1:0]  sv, cv;
    state_t                        after_edge;

    // Border position and the edge's coordinates split along and across it
    always_comb begin
        bd = $signed({cfg.border, {COORD_FRAC_BITS{1'b0}}});
        au = cfg.on_x ? a_reg.x : a_reg.y;
        bu = cfg.on_x ? b_reg.x : b_reg.y;
        av = cfg.on_x ? a_reg.y : a_reg.x;
        bv = cfg.on_x ? b_reg.y : b_reg.x;
        ia = cfg.is_max ? (au <= bd) : (au >= bd);
        ib = cfg.is_max ? (bu <= bd) : (bu >= bd);
        dv = DIFF_WIDTH'(bv) - DIFF_WIDTH'(av);
        dn = DIFF_WIDTH'(bd) - DIFF_WIDTH'(au);
        dm = DIFF_WIDTH'(bu) - DIFF_WIDTH'(au);
    end

    // Product assembly, divide step and rounding
    always_comb begin
        prod  = PROD_WIDTH'(plo_reg)
              + (PROD_WIDTH'(dmag_reg * nmag_reg[DIFF_WIDTH-1:MUL_LO_WIDTH]) << MUL_LO_WIDTH);
        trial = {rem_reg, low_reg[DIFF_WIDTH-1]};
        ge    = trial >= {1'b0, mmag_reg};
        rnd   = {rem_reg, 1'b0} >= {1'b0, mmag_reg};
        q_rnd = {1'b0, q_reg} + (DIFF_WIDTH+1)'(rnd);
        sv    = neg_reg ? -$signed({1'b0, q_rnd}) : $signed({1'b0, q_rnd});
        cv    = (DIFF_WIDTH+2)'(av) + sv;
    end

    assign can_load   = !out_valid_reg || out_ready;
    assign after_edge = closing_reg ? ST_EMIT_END : ST_CHECK_END;

    always_comb begin
        state_next     = state_reg;
        tok_next       = tok_reg;
        first_next     = first_reg;
        prev_next      = prev_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        started_next   = started_reg;
        closing_next   = closing_reg;
        ib_next        = ib_reg;
        neg_next       = neg_reg;
        dmag_next      = dmag_reg;
        nmag_next      = nmag_reg;
        mmag_next      = mmag_reg;
        plo_next       = plo_reg;
        rem_next       = rem_reg;
        low_next       = low_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        out_tok_next   = out_tok_reg;
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    tok_next   = in_tok;
                    state_next = ST_VERT;
                end
            end
            // Record the first vertex or open the edge from the previous one
            ST_VERT: begin
                closing_next = 1'b0;
                if (tok_reg.has_vertex) begin
                    prev_next = tok_reg.v;
                    if (!started_reg) begin
                        first_next   = tok_reg.v;
                        started_next = 1'b1;
                        state_next   = ST_CHECK_END;
                    end else begin
                        a_next     = prev_reg;
                        b_next     = tok_reg.v;
                        state_next = ST_EDGE;
                    end
                end else begin
                    state_next = ST_CHECK_END;
                end
            end
            // Classify both ends against the border
            ST_EDGE: begin
                ib_next   = ib;
                dmag_next = mag(dv);
                nmag_next = mag(dn);
                mmag_next = mag(dm);
                neg_next  = dv[DIFF_WIDTH-1] ^ dn[DIFF_WIDTH-1] ^ dm[DIFF_WIDTH-1];
                if (ia && ib) begin
                    state_next = ST_EMIT_B;
                end else if (!ia && !ib) begin
                    state_next = after_edge;
                end else begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1: begin
                plo_next   = dmag_reg * nmag_reg[MUL_LO_WIDTH-1:0];
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                rem_next   = prod[PROD_WIDTH-1:DIFF_WIDTH];
                low_next   = prod[DIFF_WIDTH-1:0];
                q_next     = '0;
                cnt_next   = CNT_WIDTH'(DIFF_WIDTH - 1);
                state_next = ST_DIV;
            end
            // One quotient bit per cycle
            ST_DIV: begin
                rem_next = ge ? DIFF_WIDTH'(trial - {1'b0, mmag_reg}) : trial[DIFF_WIDTH-1:0];
                low_next = {low_reg[DIFF_WIDTH-2:0], 1'b0};
                q_next   = {q_reg[DIFF_WIDTH-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_RND;
                end
            end
            // Round half away from zero and place the crossing point
            ST_RND: begin
                if (cfg.on_x) begin
                    c_next.x = bd;
                    c_next.y = cv[COORD_WIDTH-1:0];
                end else begin
                    c_next.x = cv[COORD_WIDTH-1:0];
                    c_next.y = bd;
                end
                state_next = ST_EMIT_C;
            end
            ST_EMIT_C: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_tok_next   = '{v: c_reg, has_vertex: 1'b1, is_end: 1'b0};
                    state_next     = ib_reg ? ST_EMIT_B : after_edge;
                end
            end
            ST_EMIT_B: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_tok_next   = '{v: b_reg, has_vertex: 1'b1, is_end: 1'b0};
                    state_next     = after_edge;
                end
            end
            // Close the polygon back to its first vertex
            ST_CHECK_END: begin
                if (tok_reg.is_end) begin
                    started_next = 1'b0;
                    if (started_reg) begin
                        a_next       = prev_reg;
                        b_next       = first_reg;
                        closing_next = 1'b1;
                        state_next   = ST_EDGE;
                    end else begin
                        state_next = ST_EMIT_END;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT_END: begin
                if (can_load) begin
                    out_valid_next = 1'b1;
                    out_tok_next   = '{v: '0, has_vertex: 1'b0, is_end: 1'b1};
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            started_reg   <= 1'b0;
            closing_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            started_reg   <= started_next;
            closing_reg   <= closing_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg     <= tok_next;
        first_reg   <= first_next;
        prev_reg    <= prev_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        c_reg       <= c_next;
        ib_reg      <= ib_next;
        neg_reg     <= neg_next;
        dmag_reg    <= dmag_next;
        nmag_reg    <= nmag_next;
        mmag_reg    <= mmag_next;
        plo_reg     <= plo_next;
        rem_reg     <= rem_next;
        low_reg     <= low_next;
        q_reg       <= q_next;
        cnt_reg     <= cnt_next;
        out_tok_reg <= out_tok_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_tok   = out_tok_reg;

endmodule

FILE: src/rpc_out.sv
// Output stage: holds one vertex back so the final one carries the last mark.
module rpc_out
    import rpc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  tok_t                   in_tok,
    output logic                   out_valid,
    input  logic                   out_ready,
    output vtx_t                   out_v,
    output logic                   out_last,
    output logic                   out_empty
);

    logic pend_valid_reg, pend_valid_next;
    vtx_t pend_reg, pend_next;
    logic out_valid_reg, out_valid_next;
    vtx_t out_v_reg, out_v_next;
    logic out_last_reg, out_last_next;
    logic out_empty_reg, out_empty_next;
    logic take;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    // Release the held vertex on a new vertex or at the end of the polygon
    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_v_next      = out_v_reg;
        out_last_next   = out_last_reg;
        out_empty_next  = out_empty_reg;
        if (take) begin
            if (in_tok.is_end) begin
                out_valid_next  = 1'b1;
                out_v_next      = pend_valid_reg ? pend_reg : '0;
                out_last_next   = 1'b1;
                out_empty_next  = !pend_valid_reg;
                pend_valid_next = 1'b0;
            end else if (in_tok.has_vertex) begin
                if (pend_valid_reg) begin
                    out_valid_next = 1'b1;
                    out_v_next     = pend_reg;
                    out_last_next  = 1'b0;
                    out_empty_next = 1'b0;
                end
                pend_next       = in_tok.v;
                pend_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg      <= pend_next;
        out_v_reg     <= out_v_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign out_valid = out_valid_reg;
    assign out_v     = out_v_reg;
    assign out_last  = out_last_reg;
    assign out_empty = out_empty_reg;

endmodule

FILE: src/rect_polygon_clipper_unit.sv
// Each of the four border cells accepts one vertex at a time and, per border crossing, adds
// a split multiply, a serial divide of 33 quotient bits, rounding and emit. A cell takes no
// new vertex until it is through with the last one, so the serial divider in each cell sets
// the rate when edges cross a border. The final vertex appears only after the polygon ends.
// Reset: aresetn synchronous, active low; borders return to 0 / 4095 / 0 / 4095 and all
// cells and the output stage drop any partial polygon.
module rect_polygon_clipper_unit
    import rpc_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [2*COORD_WIDTH-1:0] s_tdata,   // vertex_x, vertex_y
    input  logic                    s_tlast,   // last_vertex
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [2*COORD_WIDTH-1:0] m_tdata,   // out_x, out_y
    output logic                    m_tlast,   // out_last
    output logic                    m_tuser,   // polygon_empty
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [BORDER_WIDTH-1:0] cfg_wdata
);

    logic signed [BORDER_WIDTH-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    edge_cfg_t cfg [4];
    logic      vld [5];
    logic      rdy [5];
    tok_t      tok [5];
    vtx_t      out_v;

    // Border registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg <= BORDER_WIDTH'(0);
            x_max_reg <= BORDER_WIDTH'(4095);
            y_min_reg <= BORDER_WIDTH'(0);
            y_max_reg <= BORDER_WIDTH'(4095);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_X_MIN: x_min_reg <= cfg_wdata;
                REG_X_MAX: x_max_reg <= cfg_wdata;
                REG_Y_MIN: y_min_reg <= cfg_wdata;
                REG_Y_MAX: y_max_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Cell order: x max, x min, y max, y min
    assign cfg[0] = '{border: x_max_reg, on_x: 1'b1, is_max: 1'b1};
    assign cfg[1] = '{border: x_min_reg, on_x: 1'b1, is_max: 1'b0};
    assign cfg[2] = '{border: y_max_reg, on_x: 1'b0, is_max: 1'b1};
    assign cfg[3] = '{border: y_min_reg, on_x: 1'b0, is_max: 1'b0};

    assign vld[0]   = s_tvalid;
    assign s_tready = rdy[0];
    assign tok[0]   = '{v: '{x: s_tdata[COORD_WIDTH-1:0], y: s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]},
                        has_vertex: 1'b1, is_end: s_tlast};

    for (genvar i = 0; i < 4; i++) begin : g_cell
        rpc_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cfg       (cfg[i]),
            .in_valid  (vld[i]),
            .in_ready  (rdy[i]),
            .in_tok    (tok[i]),
            .out_valid (vld[i+1]),
            .out_ready (rdy[i+1]),
            .out_tok   (tok[i+1])
        );
    end

    rpc_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld[4]),
        .in_ready  (rdy[4]),
        .in_tok    (tok[4]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_v     (out_v),
        .out_last  (m_tlast),
        .out_empty (m_tuser)
    );

    assign m_tdata = {out_v.y, out_v.x};

    // An empty polygon is always a single, closing request
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("empty result without last mark");

    // An empty polygon carries zero coordinates
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("empty result with nonzero coordinates");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the rectangle polygon clipper: random and directed polygons.
`timescale 1ns / 1ps

module testbench;
    import rpc_pkg::*;

    typedef struct {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic                          last;
        logic                          empty;
    } clip_out_t;

    typedef struct {
        longint x;
        longint y;
    } point_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [2*COORD_WIDTH-1:0] s_tdata;
    logic                     s_tlast;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [2*COORD_WIDTH-1:0] m_tdata;
    logic                     m_tlast;
    logic                     m_tuser;
    logic                     cfg_we;
    logic [1:0]               cfg_index;
    logic [BORDER_WIDTH-1:0]  cfg_wdata;

    rect_polygon_clipper_unit DUT (.*);

    // Predictor state
    longint    border_x_min, border_x_max, border_y_min, border_y_max;
    point_t    first_pt[4];
    point_t    prev_pt[4];
    bit        started[4];
    bit        held_valid;
    point_t    held_pt;
    clip_out_t clipped_q[$];

    int        errors;
    int        send_idle_pct;
    int        recv_stall_pct;
    longint    cycle_count;

    // Clock
    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    // Guard against hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    // round(d*n/m), half away from zero
    function automatic longint cross_offset(input longint d, input longint n, input longint m);
        logic [127:0] p, q, r, md;
        bit           neg;
        neg = ((d < 0) != (n < 0)) != (m < 0);
        md  = 128'(m < 0 ? -m : m);
        p   = 128'(d < 0 ? -d : d) * 128'(n < 0 ? -n : n);
        if (md == 0) return 0;
        q = p / md;
        r = p % md;
        if (r >= md - r) q++;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint border_scaled(input int s);
        longint b;
        b = (s == 0) ? border_x_max : (s == 1) ? border_x_min :
            (s == 2) ? border_y_max : border_y_min;
        return b * 65536;
    endfunction

    task automatic emit_clipped(input longint x, input longint y, input bit last, input bit empty);
        clip_out_t o;
        o.x = x[COORD_WIDTH-1:0];
        o.y = y[COORD_WIDTH-1:0];
        o.last = last;
        o.empty = empty;
        clipped_q.push_back(o);
    endtask

    task automatic take_final(input point_t p);
        if (held_valid) emit_clipped(held_pt.x, held_pt.y, 1'b0, 1'b0);
        held_pt = p;
        held_valid = 1'b1;
    endtask

    task automatic clip_edge(input int s, input point_t a, input point_t b);
        bit     on_x, is_max, ia, ib;
        longint bd, ca, cb;
        point_t c;
        on_x   = (s < 2);
        is_max = (s == 0 || s == 2);
        bd = border_scaled(s);
        ca = on_x ? a.x : a.y;
        cb = on_x ? b.x : b.y;
        ia = is_max ? (ca <= bd) : (ca >= bd);
        ib = is_max ? (cb <= bd) : (cb >= bd);
        if (!ia && !ib) return;
        if (ia && ib) begin
            pass_on(s, b);
            return;
        end
        if (on_x) begin
            c.x = bd;
            c.y = a.y + cross_offset(b.y - a.y, bd - a.x, b.x - a.x);
        end else begin
            c.y = bd;
            c.x = a.x + cross_offset(b.x - a.x, bd - a.y, b.y - a.y);
        end
        pass_on(s, c);
        if (ib) pass_on(s, b);
    endtask

    task automatic stage_take(input int s, input point_t p);
        if (!started[s]) begin
            first_pt[s] = p;
            started[s] = 1'b1;
        end else begin
            clip_edge(s, prev_pt[s], p);
        end
        prev_pt[s] = p;
    endtask

    task automatic pass_on(input int s, input point_t p);
        if (s == 3) take_final(p);
        else stage_take(s + 1, p);
    endtask

    task automatic predict_vertex(input logic [2*COORD_WIDTH-1:0] data, input bit last);
        point_t p;
        p.x = longint'($signed(data[COORD_WIDTH-1:0]));
        p.y = longint'($signed(data[2*COORD_WIDTH-1:COORD_WIDTH]));
        stage_take(0, p);
        if (last) begin
            for (int s = 0; s < 4; s++) begin
                if (started[s]) clip_edge(s, prev_pt[s], first_pt[s]);
                started[s] = 1'b0;
            end
            if (held_valid) emit_clipped(held_pt.x, held_pt.y, 1'b1, 1'b0);
            else emit_clipped(0, 0, 1'b1, 1'b1);
            held_valid = 1'b0;
        end
    endtask

    // Check each accepted result against the oldest prediction
    always @(posedge aclk) begin
        clip_out_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (clipped_q.size() == 0) begin
                report_mismatch("unexpected result");
            end else begin
                e = clipped_q.pop_front();
                if (m_tuser !== e.empty)
                    report_mismatch($sformatf("empty %0b exp %0b", m_tuser, e.empty));
                if (m_tlast !== e.last)
                    report_mismatch($sformatf("last %0b exp %0b", m_tlast, e.last));
                if (m_tdata[COORD_WIDTH-1:0] !== e.x)
                    report_mismatch($sformatf("x %h exp %h", m_tdata[COORD_WIDTH-1:0], e.x));
                if (m_tdata[2*COORD_WIDTH-1:COORD_WIDTH] !== e.y)
                    report_mismatch($sformatf("y %h exp %h",
                        m_tdata[2*COORD_WIDTH-1:COORD_WIDTH], e.y));
            end
        end
    end

    // Random receiver stall
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Send one vertex request and predict its results; valid stays high for the next request
    task automatic send_vertex(input longint x, input longint y, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y[COORD_WIDTH-1:0], x[COORD_WIDTH-1:0]};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_vertex({y[COORD_WIDTH-1:0], x[COORD_WIDTH-1:0]}, last);
    endtask

    // Drop valid and wait for every expected result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (clipped_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_border(input logic [1:0] idx, input longint val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[BORDER_WIDTH-1:0];
        @(posedge aclk);
        case (idx)
            REG_X_MIN: border_x_min = longint'($signed(val[BORDER_WIDTH-1:0]));
            REG_X_MAX: border_x_max = longint'($signed(val[BORDER_WIDTH-1:0]));
            REG_Y_MIN: border_y_min = longint'($signed(val[BORDER_WIDTH-1:0]));
            default:   border_y_max = longint'($signed(val[BORDER_WIDTH-1:0]));
        endcase
    endtask

    task automatic set_rect(input longint x0, input longint x1, input longint y0, input longint y1);
        write_border(REG_X_MIN, x0);
        write_border(REG_X_MAX, x1);
        write_border(REG_Y_MIN, y0);
        write_border(REG_Y_MAX, y1);
        cfg_we <= 1'b0;
    endtask

    function automatic longint rand_coord();
        case ($urandom_range(5))
            0: return longint'($signed($urandom()));
            1: return longint'($signed(32'h8000_0000)) + $urandom_range(3);
            2: return 64'sh7fff_ffff - $urandom_range(3);
            default: return (longint'($urandom_range(6000)) - 1000) * 65536
                            + $urandom_range(65535);
        endcase
    endfunction

    // Extremes and special cases
    task automatic test_directed();
        send_vertex(100 * 65536, 100 * 65536, 1'b1);          // single inside vertex
        send_vertex(-5 * 65536, 100 * 65536, 1'b1);           // single outside vertex
        send_vertex(0, 0, 1'b0);                              // corners on borders
        send_vertex(4095 * 65536, 0, 1'b0);
        send_vertex(4095 * 65536, 4095 * 65536, 1'b1);
        send_vertex(-2000 * 65536, 2000 * 65536, 1'b0);       // crosses every border
        send_vertex(2000 * 65536, -2000 * 65536, 1'b0);
        send_vertex(6000 * 65536, 2000 * 65536, 1'b0);
        send_vertex(2000 * 65536, 6000 * 65536, 1'b1);
        send_vertex(64'sh7fff_ffff, 64'sh7fff_ffff, 1'b0);    // field extremes
        send_vertex(-64'sh8000_0000, 64'sh7fff_ffff, 1'b0);
        send_vertex(-64'sh8000_0000, -64'sh8000_0000, 1'b0);
        send_vertex(64'sh7fff_ffff, -64'sh8000_0000, 1'b1);
        send_vertex(-10 * 65536, -10 * 65536, 1'b0);          // fully clipped
        send_vertex(-20 * 65536, -5 * 65536, 1'b1);
        send_vertex(1, 3, 1'b0);                              // rounding ties
        send_vertex(-3, 5, 1'b1);
        drain_results();
    endtask

    task automatic test_random_polygons(input int n_items);
        int sent, len;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(12, 1) : $urandom_range(6, 3);
            for (int i = 0; i < len; i++)
                send_vertex(rand_coord(), rand_coord(), i == len - 1);
            sent += len;
        end
    endtask

    initial begin
        errors = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b1;
        cfg_we = 1'b0;
        cfg_index = REG_X_MIN;
        cfg_wdata = '0;
        border_x_min = 0; border_x_max = 4095; border_y_min = 0; border_y_max = 4095;
        held_valid = 1'b0;
        for (int s = 0; s < 4; s++) started[s] = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();

        // No idling
        test_random_polygons(60);
        drain_results();
        set_rect(-32768, 32767, -32768, 32767);
        send_idle_pct = 59;
        test_random_polygons(60);
        drain_results();
        set_rect(-100, 300, 50, 2000);
        send_idle_pct = 0;
        recv_stall_pct = 59;
        test_random_polygons(60);
        drain_results();
        set_rect(500, 100, 500, 100);                         // inverted rectangle
        send_idle_pct = 37;
        recv_stall_pct = 37;
        test_random_polygons(30);
        drain_results();
        set_rect(32767, 32767, -32768, -32768);
        test_random_polygons(30);
        drain_results();
        set_rect(0, 4095, 0, 4095);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random_polygons(60);
        drain_results();

        if (errors == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
